// File: src/parb_pkg.sv
// Package for the period audio ring buffer: field widths, request codes,
// register indexes and reset values shared by the core, geometry unit and checker.
// No dependencies.
`default_nettype none

package parb_pkg;

    localparam int STORE_BYTES_DEF = 65536;
    localparam int MAX_PERIODS_DEF = 256;
    localparam int TAG_BITS_DEF    = 16;

    localparam int PB_W   = 15;   // period_bytes register
    localparam int BP_W   = 9;    // buffer_periods register
    localparam int TAG_W  = 16;   // packet tag field
    localparam int BYTE_W = 8;
    localparam int REQ_W  = 2;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PAD     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DISCARD = 2'd3;

    localparam logic [1:0] REG_PERIOD_BYTES   = 2'd0;
    localparam logic [1:0] REG_BUFFER_PERIODS = 2'd1;
    localparam logic [1:0] REG_SWAP_BYTES     = 2'd2;

    localparam logic [PB_W-1:0] PERIOD_BYTES_RST   = 15'd4096;
    localparam logic [BP_W-1:0] BUFFER_PERIODS_RST = 9'd16;

endpackage

`default_nettype wire

// File: src/period_audio_ring_buffer_core.sv
// Period audio ring buffer, top level: APB register file, ring control,
// sample store and period tag memory, result staging.
// Depends on parb_pkg and parb_geom.
//
// Usage: configure period_bytes, buffer_periods and swap_bytes over APB while
// the block is idle; a write to either geometry register empties the ring.
// Input words (i_valid/o_ready) carry a request: write byte, end-of-stream pad,
// read byte or discard. Every input word gives exactly one result word
// (o_valid/i_ready).
// The result is registered in the staging register, beside the synchronous
// store and tag reads, and then moves into the output register. Write, read
// and discard requests do not hold off the next input word unless the output
// stalls. A pad holds o_ready low while the single store write port walks the
// rest of the period with zero bytes, at most the clamped period size minus one
// and no more than the free room. Reset and each geometry write start the geometry
// unit, which holds o_ready low through its divide, clamp and multiply steps.
// When the receiver stalls, the output register holds its word and one more
// result waits in the staging register; o_ready then drops until i_ready.
`default_nettype none

module period_audio_ring_buffer_core
    import parb_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    parameter int MAX_PERIODS = MAX_PERIODS_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [TAG_W-1:0]  i_packet_tag,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_accepted,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_out_valid,
    output logic [TAG_W-1:0]  o_playing_tag,
    output logic              o_playing_valid,
    output logic              o_buffer_empty
);

    localparam int AW      = $clog2(STORE_BYTES);
    localparam int FW      = $clog2(STORE_BYTES + 1);
    localparam int PW      = $clog2(MAX_PERIODS);
    localparam int NW      = $clog2(MAX_PERIODS + 1);
    localparam int TagKeep = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int SumW    = ((AW > PB_W) ? AW : PB_W) + 1;
    localparam int CW      = (FW > PB_W) ? FW : PB_W;

    typedef enum logic [1:0] {
        S_RUN = 2'b01,
        S_PAD = 2'b10
    } t_state;

    // configuration
    logic [PB_W-1:0]  r_period_bytes;
    logic [BP_W-1:0]  r_buffer_periods;
    logic             r_swap;
    logic             r_geom_start;
    logic             cfg_wr;
    logic             cfg_geom;

    // geometry
    logic             geom_busy;
    logic [PB_W-1:0]  pb;
    logic [NW-1:0]    nper;
    logic [FW-1:0]    size;

    // ring state
    t_state           r_state,     n_state;
    logic [AW-1:0]    r_wp,        n_wp;
    logic [AW-1:0]    r_rp,        n_rp;
    logic [FW-1:0]    r_fill,      n_fill;
    logic [PB_W-1:0]  r_off,       n_off;
    logic             r_in_flight, n_in_flight;
    logic [PB_W-1:0]  r_wr_off,    n_wr_off;
    logic [PW-1:0]    r_wr_per,    n_wr_per;
    logic [PW-1:0]    r_rd_per,    n_rd_per;
    logic [PB_W-1:0]  r_pad_left,  n_pad_left;
    logic [MAX_PERIODS-1:0] r_present;

    // memories
    logic [BYTE_W-1:0]  r_store [STORE_BYTES];
    logic [TagKeep-1:0] r_tags  [MAX_PERIODS];
    logic [BYTE_W-1:0]  r_byte_q;
    logic [TagKeep-1:0] r_tag_q;

    // staging and output registers
    logic               r_b_valid;
    logic               r_b_accepted;
    logic               r_b_ovalid;
    logic               r_b_pvalid;
    logic               r_b_empty;
    logic               r_b_fwd;
    logic [TagKeep-1:0] r_b_fwd_tag;
    logic               r_o_valid;
    logic               r_o_accepted;
    logic [BYTE_W-1:0]  r_o_byte;
    logic               r_o_ovalid;
    logic [TAG_W-1:0]   r_o_ptag;
    logic               r_o_pvalid;
    logic               r_o_empty;

    // step logic
    logic               in_acc;
    logic               b_move;
    logic               do_store_wr;
    logic [BYTE_W-1:0]  store_wr_data;
    logic               do_tag_wr;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wp_inc;
    logic               wr_off_last;
    logic [PB_W-1:0]    wr_off_inc;
    logic [PW-1:0]      wr_per_inc;
    logic [PW-1:0]      rd_per_inc;
    logic [SumW-1:0]    rp_sum;
    logic [AW-1:0]      rp_adv;
    logic [PB_W-1:0]    rd_off;
    logic [PB_W-1:0]    rd_src;
    logic               rd_start;
    logic [PB_W-1:0]    pad_len;
    logic [FW-1:0]      room;
    logic [PB_W-1:0]    pad;
    logic               res_accepted;
    logic               res_ovalid;
    logic               res_pvalid;
    logic               present_new;

    // ---------------------------------------------------------------- APB
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_geom = cfg_wr && ((paddr[ADDR_W-1:2] == REG_PERIOD_BYTES) ||
                                 (paddr[ADDR_W-1:2] == REG_BUFFER_PERIODS));

    always_comb begin
        unique case (paddr[ADDR_W-1:2])
            REG_PERIOD_BYTES:   prdata = DATA_W'(r_period_bytes);
            REG_BUFFER_PERIODS: prdata = DATA_W'(r_buffer_periods);
            REG_SWAP_BYTES:     prdata = DATA_W'(r_swap);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_bytes   <= PERIOD_BYTES_RST;
            r_buffer_periods <= BUFFER_PERIODS_RST;
            r_swap           <= 1'b0;
            r_geom_start     <= 1'b1;
        end else begin
            r_geom_start <= cfg_geom;
            if (cfg_wr) begin
                unique case (paddr[ADDR_W-1:2])
                    REG_PERIOD_BYTES:   r_period_bytes   <= pwdata[PB_W-1:0];
                    REG_BUFFER_PERIODS: r_buffer_periods <= pwdata[BP_W-1:0];
                    REG_SWAP_BYTES:     r_swap           <= pwdata[0];
                    default:            ;
                endcase
            end
        end
    end

    parb_geom #(
        .STORE_BYTES (STORE_BYTES),
        .MAX_PERIODS (MAX_PERIODS)
    ) u_geom (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (r_geom_start),
        .i_period_bytes   (r_period_bytes),
        .i_buffer_periods (r_buffer_periods),
        .o_busy           (geom_busy),
        .o_pb             (pb),
        .o_nper           (nper),
        .o_size           (size)
    );

    // ---------------------------------------------------------------- handshake
    assign b_move  = r_b_valid && (!r_o_valid || i_ready);
    assign o_ready = (r_state == S_RUN) && !geom_busy && (!r_b_valid || b_move);
    assign in_acc  = i_valid && o_ready;

    // ---------------------------------------------------------------- position arithmetic
    assign wp_inc      = ((FW'(r_wp) + FW'(1)) == size) ? '0 : (r_wp + AW'(1));
    assign wr_off_inc  = r_wr_off + PB_W'(1);
    assign wr_off_last = wr_off_inc == pb;
    assign wr_per_inc  = ((NW'(r_wr_per) + NW'(1)) == nper) ? '0 : (r_wr_per + PW'(1));
    assign rd_per_inc  = ((NW'(r_rd_per) + NW'(1)) == nper) ? '0 : (r_rd_per + PW'(1));
    assign rp_sum      = SumW'(r_rp) + SumW'(pb);
    assign rp_adv      = (rp_sum >= SumW'(size)) ? AW'(rp_sum - SumW'(size)) : AW'(rp_sum);

    assign rd_start = !r_in_flight && (CW'(r_fill) >= CW'(pb));
    assign rd_off   = rd_start ? '0 : r_off;
    assign rd_src   = r_swap ? (rd_off ^ PB_W'(1)) : rd_off;

    assign pad_len  = pb - r_wr_off;
    assign room     = size - r_fill;
    assign pad      = (CW'(pad_len) > CW'(room)) ? PB_W'(room) : pad_len;

    always_comb begin
        n_state       = r_state;
        n_wp          = r_wp;
        n_rp          = r_rp;
        n_fill        = r_fill;
        n_off         = r_off;
        n_in_flight   = r_in_flight;
        n_wr_off      = r_wr_off;
        n_wr_per      = r_wr_per;
        n_rd_per      = r_rd_per;
        n_pad_left    = r_pad_left;
        do_store_wr   = 1'b0;
        store_wr_data = '0;
        do_tag_wr     = 1'b0;
        rd_addr       = r_rp;
        res_accepted  = 1'b0;
        res_ovalid    = 1'b0;

        if (r_state == S_PAD) begin
            // walk the zero fill up to the period boundary
            do_store_wr = 1'b1;
            n_wp        = wp_inc;
            n_wr_off    = wr_off_last ? '0 : wr_off_inc;
            n_wr_per    = wr_off_last ? wr_per_inc : r_wr_per;
            n_pad_left  = r_pad_left - PB_W'(1);
            if (r_pad_left == PB_W'(1)) begin
                n_state = S_RUN;
            end
        end else if (in_acc) begin
            unique case (i_req_type)
                REQ_WRITE: begin
                    if (r_fill < size) begin
                        do_store_wr   = 1'b1;
                        store_wr_data = i_data_byte;
                        do_tag_wr     = 1'b1;
                        n_wp          = wp_inc;
                        n_wr_off      = wr_off_last ? '0 : wr_off_inc;
                        n_wr_per      = wr_off_last ? wr_per_inc : r_wr_per;
                        n_fill        = r_fill + FW'(1);
                        res_accepted  = 1'b1;
                    end
                end
                REQ_PAD: begin
                    if ((r_wr_off != '0) && (pad != '0)) begin
                        n_fill     = r_fill + FW'(pad);
                        n_pad_left = pad;
                        n_state    = S_PAD;
                    end
                end
                REQ_READ: begin
                    if (r_in_flight || rd_start) begin
                        rd_addr    = AW'(SumW'(r_rp) + SumW'(rd_src));
                        res_ovalid = 1'b1;
                        if ((rd_off + PB_W'(1)) == pb) begin
                            // last byte: free the period
                            n_in_flight = 1'b0;
                            n_off       = '0;
                            n_rp        = rp_adv;
                            n_rd_per    = rd_per_inc;
                            n_fill      = (CW'(r_fill) >= CW'(pb)) ? (r_fill - FW'(pb)) : '0;
                        end else begin
                            n_in_flight = 1'b1;
                            n_off       = rd_off + PB_W'(1);
                        end
                    end
                end
                REQ_DISCARD: begin
                    // keep only the period in flight
                    n_wr_off = '0;
                    if (r_in_flight) begin
                        n_wp     = rp_adv;
                        n_wr_per = rd_per_inc;
                        n_fill   = FW'(pb);
                    end else begin
                        n_wp     = r_rp;
                        n_wr_per = r_rd_per;
                        n_fill   = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign present_new = r_present[n_rd_per] || (do_tag_wr && (r_wr_per == n_rd_per));
    assign res_pvalid  = (n_fill != '0) && present_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_wp        <= '0;
            r_rp        <= '0;
            r_fill      <= '0;
            r_off       <= '0;
            r_in_flight <= 1'b0;
            r_wr_off    <= '0;
            r_wr_per    <= '0;
            r_rd_per    <= '0;
            r_pad_left  <= '0;
            r_present   <= '0;
        end else if (cfg_geom) begin
            r_state     <= S_RUN;
            r_wp        <= '0;
            r_rp        <= '0;
            r_fill      <= '0;
            r_off       <= '0;
            r_in_flight <= 1'b0;
            r_wr_off    <= '0;
            r_wr_per    <= '0;
            r_rd_per    <= '0;
            r_pad_left  <= '0;
            r_present   <= '0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_fill      <= n_fill;
            r_off       <= n_off;
            r_in_flight <= n_in_flight;
            r_wr_off    <= n_wr_off;
            r_wr_per    <= n_wr_per;
            r_rd_per    <= n_rd_per;
            r_pad_left  <= n_pad_left;
            if (do_tag_wr) begin
                r_present[r_wr_per] <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- memories
    always_ff @(posedge i_clk) begin
        if (do_store_wr) begin
            r_store[r_wp] <= store_wr_data;
        end
        if (in_acc) begin
            r_byte_q <= r_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_tag_wr) begin
            r_tags[r_wr_per] <= i_packet_tag[TagKeep-1:0];
        end
        if (in_acc) begin
            r_tag_q <= r_tags[n_rd_per];
        end
    end

    // ---------------------------------------------------------------- staging and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_b_valid <= 1'b1;
            end else if (b_move) begin
                r_b_valid <= 1'b0;
            end
            if (b_move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_accepted <= res_accepted;
            r_b_ovalid   <= res_ovalid;
            r_b_pvalid   <= res_pvalid;
            r_b_empty    <= n_fill == '0;
            // forward a tag written in the same cycle as its read
            r_b_fwd      <= do_tag_wr && (r_wr_per == n_rd_per);
            r_b_fwd_tag  <= i_packet_tag[TagKeep-1:0];
        end
        if (b_move) begin
            r_o_accepted <= r_b_accepted;
            r_o_byte     <= r_b_ovalid ? r_byte_q : '0;
            r_o_ovalid   <= r_b_ovalid;
            r_o_ptag     <= r_b_pvalid ? (r_b_fwd ? TAG_W'(r_b_fwd_tag) : TAG_W'(r_tag_q))
                                       : '0;
            r_o_pvalid   <= r_b_pvalid;
            r_o_empty    <= r_b_empty;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_accepted      = r_o_accepted;
    assign o_out_byte      = r_o_byte;
    assign o_out_valid     = r_o_ovalid;
    assign o_playing_tag   = r_o_ptag;
    assign o_playing_valid = r_o_pvalid;
    assign o_buffer_empty  = r_o_empty;

endmodule

`default_nettype wire

// File: src/parb_geom.sv
// Geometry unit: clamps the period size and works out the period count and ring
// size, dividing the store size by the period size one quotient bit a cycle.
// Depends on parb_pkg.
`default_nettype none

module parb_geom
    import parb_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    parameter int MAX_PERIODS = MAX_PERIODS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [PB_W-1:0]                      i_period_bytes,
    input  logic [BP_W-1:0]                      i_buffer_periods,
    output logic                                 o_busy,
    output logic [PB_W-1:0]                      o_pb,
    output logic [$clog2(MAX_PERIODS+1)-1:0]     o_nper,
    output logic [$clog2(STORE_BYTES+1)-1:0]     o_size
);

    localparam int QW = $clog2(STORE_BYTES + 1);
    localparam int NW = $clog2(MAX_PERIODS + 1);
    localparam int FW = $clog2(STORE_BYTES + 1);
    localparam int CW = $clog2(QW + 1);
    localparam logic [PB_W-1:0] PbMax = PB_W'(STORE_BYTES & ~1);

    typedef enum logic [3:0] {
        G_IDLE  = 4'b0001,
        G_DIV   = 4'b0010,
        G_CLAMP = 4'b0100,
        G_MUL   = 4'b1000
    } t_gstate;

    t_gstate          r_state;
    logic [PB_W-1:0]  r_pb;
    logic [PB_W:0]    r_rem;
    logic [QW-1:0]    r_dvd;
    logic [QW-1:0]    r_q;
    logic [CW-1:0]    r_cnt;
    logic [NW-1:0]    r_nper;
    logic [FW-1:0]    r_size;

    logic [PB_W-1:0]  pb_eff;
    logic [PB_W:0]    rem_sh;
    logic             rem_ge;
    logic [31:0]      n_clamp;

    always_comb begin
        pb_eff = {i_period_bytes[PB_W-1:1], 1'b0};
        if (pb_eff < PB_W'(2)) begin
            pb_eff = PB_W'(2);
        end else if (32'(pb_eff) > STORE_BYTES) begin
            pb_eff = PbMax;
        end
    end

    assign rem_sh = {r_rem[PB_W-1:0], r_dvd[QW-1]};
    assign rem_ge = rem_sh >= {1'b0, r_pb};

    always_comb begin
        n_clamp = 32'(i_buffer_periods);
        if (n_clamp == 32'd0) begin
            n_clamp = 32'd1;
        end
        if (n_clamp > 32'(MAX_PERIODS)) begin
            n_clamp = 32'(MAX_PERIODS);
        end
        if (n_clamp > 32'(r_q)) begin
            n_clamp = 32'(r_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
        end else if (i_start) begin
            r_state <= G_DIV;
        end else begin
            unique case (r_state)
                G_IDLE:  r_state <= G_IDLE;
                G_DIV:   if (r_cnt == CW'(1)) r_state <= G_CLAMP;
                G_CLAMP: r_state <= G_MUL;
                G_MUL:   r_state <= G_IDLE;
                default: r_state <= G_IDLE;
            endcase
        end
    end

    // datapath: restoring division of the store size by the period size
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_pb  <= pb_eff;
            r_rem <= '0;
            r_dvd <= QW'(STORE_BYTES);
            r_q   <= '0;
            r_cnt <= CW'(QW);
        end else if (r_state == G_DIV) begin
            r_rem <= rem_ge ? (rem_sh - {1'b0, r_pb}) : rem_sh;
            r_q   <= {r_q[QW-2:0], rem_ge};
            r_dvd <= {r_dvd[QW-2:0], 1'b0};
            r_cnt <= r_cnt - CW'(1);
        end else if (r_state == G_CLAMP) begin
            r_nper <= NW'(n_clamp);
        end else if (r_state == G_MUL) begin
            r_size <= FW'(32'(r_nper) * 32'(r_pb));
        end
    end

    assign o_busy = i_start || (r_state != G_IDLE);
    assign o_pb   = r_pb;
    assign o_nper = r_nper;
    assign o_size = r_size;

endmodule

`default_nettype wire

// File: src/parb_chk.sv
// Port-level checker for the period audio ring buffer core, attached by bind.
// Depends on parb_pkg and period_audio_ring_buffer_core.
`default_nettype none

module parb_chk
    import parb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_accepted,
    input logic [BYTE_W-1:0] o_out_byte,
    input logic              o_out_valid,
    input logic [TAG_W-1:0]  o_playing_tag,
    input logic              o_playing_valid,
    input logic              o_buffer_empty
);

    // a stored write and a delivered byte never share one word
    a_write_not_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |-> !o_out_valid)
        else $error("write result also shows a delivered byte");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_valid |-> o_out_byte == '0)
        else $error("byte not zero without delivery");

    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_playing_valid |-> o_playing_tag == '0)
        else $error("playing tag not zero while invalid");

    a_empty_no_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_buffer_empty |-> !o_playing_valid)
        else $error("playing tag valid on an empty buffer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_playing_tag))
        else $error("stalled result word changed");

endmodule

bind period_audio_ring_buffer_core parb_chk u_parb_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_accepted      (o_accepted),
    .o_out_byte      (o_out_byte),
    .o_out_valid     (o_out_valid),
    .o_playing_tag   (o_playing_tag),
    .o_playing_valid (o_playing_valid),
    .o_buffer_empty  (o_buffer_empty)
);

`default_nettype wire
